>>> rtl/core/tw3d_pkg.sv
package tw3d_pkg;

	// width of the duration and delay registers
	localparam int DUR_W = 16;
	localparam int NUM_AXES = 3;

	localparam logic [1:0] AXIS_LAST = 2'd2;

	localparam logic [DUR_W-1:0] DURATION_RESET = 16'd1000;

	// input item kinds
	localparam logic [1:0] KIND_TICK = 2'd0;
	localparam logic [1:0] KIND_MOVE = 2'd1;
	localparam logic [1:0] KIND_JUMP = 2'd2;

	// register indexes
	localparam logic [1:0] REG_DURATION = 2'd0;
	localparam logic [1:0] REG_DELAY_X  = 2'd1;
	localparam logic [1:0] REG_DELAY_Y  = 2'd2;
	localparam logic [1:0] REG_DELAY_Z  = 2'd3;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DISPATCH,
		ST_CHECK,
		ST_DIV,
		ST_MUL1,
		ST_MUL2,
		ST_WB,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic       load_in;
		logic       do_move;
		logic       do_jump;
		logic       hold_start;
		logic       land;
		logic       div_start;
		logic       mul1;
		logic       mul2;
		logic       write_back;
		logic       load_out;
		logic [1:0] axis;
	} cmd_t;

	typedef struct packed {
		logic [1:0] kind;
		logic       skip;
		logic       early;
		logic       land;
		logic       div_done;
		logic       out_free;
	} stat_t;

endpackage

>>> rtl/core/tw3d_div.sv
module tw3d_div #(
	parameter int FRAC_BITS = 16
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [tw3d_pkg::DUR_W-1:0]  dividend,
	input  logic [tw3d_pkg::DUR_W-1:0]  divisor,
	output logic [FRAC_BITS-1:0]        quotient,
	output logic                        done
);

	localparam int CNT_W = $clog2(FRAC_BITS + 1);

	logic [tw3d_pkg::DUR_W-1:0] rem_q;
	logic [FRAC_BITS-1:0]       quo_q;
	logic [CNT_W-1:0]           cnt_q;
	logic                       busy_q;
	logic                       done_q;
	logic [tw3d_pkg::DUR_W:0]   rem2;
	logic [tw3d_pkg::DUR_W:0]   diff;
	logic                       ge;

	// remainder stays below the divisor, so one shifted-in zero per step
	assign rem2 = {rem_q, 1'b0};
	assign diff = rem2 - {1'b0, divisor};
	assign ge   = rem2 >= {1'b0, divisor};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(FRAC_BITS);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= dividend;
			quo_q <= '0;
		end else if (busy_q) begin
			rem_q <= ge ? diff[tw3d_pkg::DUR_W-1:0] : rem2[tw3d_pkg::DUR_W-1:0];
			quo_q <= {quo_q[FRAC_BITS-2:0], ge};
		end
	end

	assign quotient = quo_q;
	assign done     = done_q;

endmodule

>>> rtl/core/tw3d_ctrl.sv
module tw3d_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_tvalid,
	output logic             s_tready,
	input  tw3d_pkg::stat_t  stat,
	output tw3d_pkg::cmd_t   cmd
);

	tw3d_pkg::state_t state_q, state_d;
	logic [1:0]       axis_q, axis_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tw3d_pkg::ST_IDLE;
			axis_q  <= '0;
		end else begin
			state_q <= state_d;
			axis_q  <= axis_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		axis_d   = axis_q;
		cmd      = '0;
		cmd.axis = axis_q;
		s_tready = 1'b0;
		case (state_q)
			tw3d_pkg::ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					cmd.load_in = 1'b1;
					state_d     = tw3d_pkg::ST_DISPATCH;
				end
			end
			tw3d_pkg::ST_DISPATCH: begin
				axis_d = '0;
				case (stat.kind)
					tw3d_pkg::KIND_TICK: state_d = tw3d_pkg::ST_CHECK;
					tw3d_pkg::KIND_MOVE: begin
						cmd.do_move = 1'b1;
						state_d     = tw3d_pkg::ST_OUT;
					end
					tw3d_pkg::KIND_JUMP: begin
						cmd.do_jump = 1'b1;
						state_d     = tw3d_pkg::ST_OUT;
					end
					default: state_d = tw3d_pkg::ST_OUT;
				endcase
			end
			tw3d_pkg::ST_CHECK: begin
				if (!stat.skip && !stat.early && !stat.land) begin
					cmd.div_start = 1'b1;
					state_d       = tw3d_pkg::ST_DIV;
				end else begin
					cmd.hold_start = !stat.skip && stat.early;
					cmd.land       = !stat.skip && !stat.early;
					if (axis_q == tw3d_pkg::AXIS_LAST) begin
						axis_d  = '0;
						state_d = tw3d_pkg::ST_OUT;
					end else begin
						axis_d = axis_q + 2'd1;
					end
				end
			end
			tw3d_pkg::ST_DIV: begin
				if (stat.div_done) begin
					state_d = tw3d_pkg::ST_MUL1;
				end
			end
			tw3d_pkg::ST_MUL1: begin
				cmd.mul1 = 1'b1;
				state_d  = tw3d_pkg::ST_MUL2;
			end
			tw3d_pkg::ST_MUL2: begin
				cmd.mul2 = 1'b1;
				state_d  = tw3d_pkg::ST_WB;
			end
			tw3d_pkg::ST_WB: begin
				cmd.write_back = 1'b1;
				if (axis_q == tw3d_pkg::AXIS_LAST) begin
					axis_d  = '0;
					state_d = tw3d_pkg::ST_OUT;
				end else begin
					axis_d  = axis_q + 2'd1;
					state_d = tw3d_pkg::ST_CHECK;
				end
			end
			tw3d_pkg::ST_OUT: begin
				if (stat.out_free) begin
					cmd.load_out = 1'b1;
					state_d      = tw3d_pkg::ST_IDLE;
				end
			end
			default: state_d = tw3d_pkg::ST_IDLE;
		endcase
	end

endmodule

>>> rtl/core/tw3d_dp.sv
module tw3d_dp #(
	parameter int COORD_WIDTH = 16,
	parameter int TIME_WIDTH  = 32,
	parameter int FRAC_BITS   = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  tw3d_pkg::cmd_t                cmd,
	output tw3d_pkg::stat_t               stat,
	input  logic [1:0]                    in_kind,
	input  logic [TIME_WIDTH-1:0]         in_now,
	input  logic signed [COORD_WIDTH-1:0] in_tgt_x,
	input  logic signed [COORD_WIDTH-1:0] in_tgt_y,
	input  logic signed [COORD_WIDTH-1:0] in_tgt_z,
	input  logic [tw3d_pkg::DUR_W-1:0]    duration,
	input  logic [tw3d_pkg::DUR_W-1:0]    delay_x,
	input  logic [tw3d_pkg::DUR_W-1:0]    delay_y,
	input  logic [tw3d_pkg::DUR_W-1:0]    delay_z,
	input  logic                          out_ready,
	output logic                          out_valid,
	output logic signed [COORD_WIDTH-1:0] pos_x,
	output logic signed [COORD_WIDTH-1:0] pos_y,
	output logic signed [COORD_WIDTH-1:0] pos_z,
	output logic                          all_done
);

	localparam int CW  = COORD_WIDTH;
	localparam int F   = FRAC_BITS;
	localparam int P1W = 2 * F + 2;
	localparam int P2W = CW + F + 2;
	localparam logic [F+1:0]   TWO_ONE   = (F+2)'(2) << F;
	localparam logic [P2W-1:0] ROUND_ADJ = (P2W'(1) << F) - P2W'(1);

	// axis state
	logic signed [CW-1:0] start_q [tw3d_pkg::NUM_AXES];
	logic signed [CW-1:0] end_q   [tw3d_pkg::NUM_AXES];
	logic signed [CW-1:0] now_q   [tw3d_pkg::NUM_AXES];
	logic [tw3d_pkg::NUM_AXES-1:0] paused_q;
	logic [tw3d_pkg::NUM_AXES-1:0] finished_q;

	// latched item
	logic [1:0]            kind_q;
	logic [TIME_WIDTH-1:0] time_q;
	logic signed [CW-1:0]  tgt_q [tw3d_pkg::NUM_AXES];

	// arithmetic
	logic [P1W-1:0]         prod1_q;
	logic signed [P2W-1:0]  prod2_q;
	logic [F-1:0]           tt;
	logic                   div_done;
	logic [tw3d_pkg::DUR_W-1:0] dly;
	logic [TIME_WIDTH-1:0]  elapsed;
	logic                   early;
	logic                   land;
	logic signed [CW:0]     span;
	logic signed [F:0]      eased_s;
	logic signed [P2W-1:0]  prod2;
	logic signed [P2W-1:0]  rnd;
	logic signed [P2W-1:0]  delta;
	logic                   same_ends;

	// output register
	logic                 out_valid_q;
	logic signed [CW-1:0] pos_q [tw3d_pkg::NUM_AXES];
	logic                 done_q;

	always_comb begin
		case (cmd.axis)
			2'd0:    dly = delay_x;
			2'd1:    dly = delay_y;
			default: dly = delay_z;
		endcase
	end

	assign early   = time_q < TIME_WIDTH'(dly);
	assign elapsed = time_q - TIME_WIDTH'(dly);
	assign land    = (duration == '0) || (elapsed >= TIME_WIDTH'(duration));

	assign stat.kind     = kind_q;
	assign stat.skip     = paused_q[cmd.axis] | finished_q[cmd.axis];
	assign stat.early    = early;
	assign stat.land     = land;
	assign stat.div_done = div_done;
	assign stat.out_free = !out_valid_q || out_ready;

	// elapsed is below the duration here, so its low bits are the whole value
	tw3d_div #(
		.FRAC_BITS(F)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (elapsed[tw3d_pkg::DUR_W-1:0]),
		.divisor  (duration),
		.quotient (tt),
		.done     (div_done)
	);

	assign span    = (CW+1)'(end_q[cmd.axis]) - (CW+1)'(start_q[cmd.axis]);
	assign eased_s = $signed({1'b0, prod1_q[2*F-1:F]});
	assign prod2   = span * eased_s;
	// truncate toward zero on the final scale
	assign rnd     = prod2_q + (prod2_q[P2W-1] ? $signed(ROUND_ADJ) : $signed(P2W'(0)));
	assign delta   = rnd >>> F;

	assign same_ends = (tgt_q[0] == end_q[0]) && (tgt_q[1] == end_q[1]) &&
		(tgt_q[2] == end_q[2]);

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			kind_q   <= in_kind;
			time_q   <= in_now;
			tgt_q[0] <= in_tgt_x;
			tgt_q[1] <= in_tgt_y;
			tgt_q[2] <= in_tgt_z;
		end
		if (cmd.mul1) begin
			prod1_q <= P1W'({{F{1'b0}}, tt} * {{(F-2){1'b0}}, TWO_ONE - (F+2)'(tt)});
		end
		if (cmd.mul2) begin
			prod2_q <= prod2;
		end
		if (cmd.load_out) begin
			pos_q  <= now_q;
			done_q <= &finished_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < tw3d_pkg::NUM_AXES; k++) begin
				start_q[k] <= '0;
				end_q[k]   <= '0;
				now_q[k]   <= '0;
			end
			paused_q    <= '1;
			finished_q  <= '1;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.do_move && !same_ends) begin
				for (int k = 0; k < tw3d_pkg::NUM_AXES; k++) begin
					start_q[k] <= now_q[k];
					end_q[k]   <= tgt_q[k];
				end
				paused_q   <= '0;
				finished_q <= '0;
			end
			if (cmd.do_jump) begin
				for (int k = 0; k < tw3d_pkg::NUM_AXES; k++) begin
					start_q[k] <= now_q[k];
					end_q[k]   <= tgt_q[k];
					now_q[k]   <= tgt_q[k];
				end
				paused_q   <= '1;
				finished_q <= '1;
			end
			if (cmd.hold_start) begin
				now_q[cmd.axis] <= start_q[cmd.axis];
			end
			if (cmd.land) begin
				now_q[cmd.axis]      <= end_q[cmd.axis];
				finished_q[cmd.axis] <= 1'b1;
			end
			if (cmd.write_back) begin
				now_q[cmd.axis] <= start_q[cmd.axis] + delta[CW-1:0];
			end
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign pos_x     = pos_q[0];
	assign pos_y     = pos_q[1];
	assign pos_z     = pos_q[2];
	assign all_done  = done_q;

endmodule

>>> rtl/core/tween_3d_per_axis_delay.sv
// three-axis eased mover with a start delay per axis
//
// input stream (s_*): one transaction per command; s_tuser carries the kind
// (tick with time, move to targets, jump to targets), s_tdata the time since
// the last move and the three targets. output stream (m_*): exactly one
// transaction per input transaction with the three positions and all_done.
// apb port: duration at 0x0, delays for x, y, z at 0x4, 0x8, 0xc; write
// only while the block is idle.
// sequence: move, jump and unused kinds go from dispatch straight to the
// output register; a tick then visits each axis in turn, in the check step
// alone when the axis is stopped, waiting or landing, or through check,
// divide, the multiplies and write back when it eases; the serial divider
// (one quotient bit a cycle) is shared by the axes.
// one command is worked on at a time; s_tready is high only between commands.
// a finished result waits in the output register while the next command is
// taken; if m_tready stays low the block stalls before loading the next one.
// reset: duration 1000, delays 0, all axes at zero, paused and finished,
// output empty
module tween_3d_per_axis_delay #(
	parameter int COORD_WIDTH = 16,
	parameter int TIME_WIDTH  = 32,
	parameter int FRAC_BITS   = 16,
	// stream widths, zero filled to whole bytes
	localparam int IN_DATA_W  = ((TIME_WIDTH + 3 * COORD_WIDTH + 7) / 8) * 8,
	localparam int OUT_DATA_W = ((3 * COORD_WIDTH + 7) / 8) * 8
) (
	input  logic                  clk,
	input  logic                  arst_n,

	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [IN_DATA_W-1:0]  s_tdata,   // now_ms, target_x, target_y, target_z
	input  logic [1:0]            s_tuser,   // kind

	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [OUT_DATA_W-1:0] m_tdata,   // pos_x, pos_y, pos_z
	output logic                  m_tuser,   // all_done

	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [3:0]            paddr,
	input  logic [31:0]           pwdata,
	output logic [31:0]           prdata,
	output logic                  pready
);

	localparam int DW         = tw3d_pkg::DUR_W;

	// configuration registers
	logic [DW-1:0] duration_q;
	logic [DW-1:0] delay_x_q;
	logic [DW-1:0] delay_y_q;
	logic [DW-1:0] delay_z_q;
	logic          cfg_write;
	logic [1:0]    reg_idx;

	tw3d_pkg::cmd_t  cmd;
	tw3d_pkg::stat_t stat;

	logic signed [COORD_WIDTH-1:0] pos_x;
	logic signed [COORD_WIDTH-1:0] pos_y;
	logic signed [COORD_WIDTH-1:0] pos_z;

	assign pready    = 1'b1;
	assign reg_idx   = paddr[3:2];
	assign cfg_write = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			duration_q <= tw3d_pkg::DURATION_RESET;
			delay_x_q  <= '0;
			delay_y_q  <= '0;
			delay_z_q  <= '0;
		end else if (cfg_write) begin
			case (reg_idx)
				tw3d_pkg::REG_DURATION: duration_q <= pwdata[DW-1:0];
				tw3d_pkg::REG_DELAY_X:  delay_x_q  <= pwdata[DW-1:0];
				tw3d_pkg::REG_DELAY_Y:  delay_y_q  <= pwdata[DW-1:0];
				tw3d_pkg::REG_DELAY_Z:  delay_z_q  <= pwdata[DW-1:0];
				default: ;
			endcase
		end
	end

	// register readback
	always_comb begin
		case (reg_idx)
			tw3d_pkg::REG_DURATION: prdata = 32'(duration_q);
			tw3d_pkg::REG_DELAY_X:  prdata = 32'(delay_x_q);
			tw3d_pkg::REG_DELAY_Y:  prdata = 32'(delay_y_q);
			tw3d_pkg::REG_DELAY_Z:  prdata = 32'(delay_z_q);
			default:                prdata = '0;
		endcase
	end

	// sequencer: one axis at a time through check, divide, two multiplies, write back
	tw3d_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	tw3d_dp #(
		.COORD_WIDTH (COORD_WIDTH),
		.TIME_WIDTH  (TIME_WIDTH),
		.FRAC_BITS   (FRAC_BITS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.stat      (stat),
		.in_kind   (s_tuser),
		.in_now    (s_tdata[TIME_WIDTH-1:0]),
		.in_tgt_x  (s_tdata[TIME_WIDTH +: COORD_WIDTH]),
		.in_tgt_y  (s_tdata[TIME_WIDTH + COORD_WIDTH +: COORD_WIDTH]),
		.in_tgt_z  (s_tdata[TIME_WIDTH + 2 * COORD_WIDTH +: COORD_WIDTH]),
		.duration  (duration_q),
		.delay_x   (delay_x_q),
		.delay_y   (delay_y_q),
		.delay_z   (delay_z_q),
		.out_ready (m_tready),
		.out_valid (m_tvalid),
		.pos_x     (pos_x),
		.pos_y     (pos_y),
		.pos_z     (pos_z),
		.all_done  (m_tuser)
	);

	// pack positions from the low bits up, zero fill to whole bytes
	assign m_tdata = OUT_DATA_W'({pos_z, pos_y, pos_x});

endmodule
